// ===== sv/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, constants and helpers of the fit page allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int NUM_PAGES   = 32;
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int COUNT_W     = $clog2(NUM_PAGES + 1);
  localparam int NUM_IDS     = 256;
  localparam int ID_AW       = $clog2(NUM_IDS);
  localparam int SIZE_W      = 16;
  localparam int NEED_W      = SIZE_W - 1;
  localparam int STATUS_W    = 3;
  localparam int FRAG_W      = 5;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic MODE_BEST = 1'b0;

  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  start;
    logic [COUNT_W-1:0] count;
  } tbl_entry_t;

  localparam int TBL_W = $bits(tbl_entry_t);

  // Bit i is set when page i lies in [start, start + count).
  function automatic logic [NUM_PAGES-1:0] range_mask(input logic [PAGE_W-1:0] start,
                                                      input logic [COUNT_W-1:0] count);
    logic [NUM_PAGES-1:0] m;
    logic [COUNT_W:0]     lim;
    lim = (COUNT_W+1)'(start) + (COUNT_W+1)'(count);
    for (int i = 0; i < NUM_PAGES; i++) begin
      m[i] = ((COUNT_W+1)'(i) >= (COUNT_W+1)'(start)) && ((COUNT_W+1)'(i) < lim);
    end
    return m;
  endfunction

endpackage

// ===== sv/fpa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface fpa_req_if import fpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [7:0]        program_id;
  logic [SIZE_W-1:0] size_kb;

  modport source (output valid, req_type, program_id, size_kb, input ready);
  modport sink   (input valid, req_type, program_id, size_kb, output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   start_page;
  logic [COUNT_W-1:0]  page_count;
  logic [FRAG_W-1:0]   free_fragments;

  modport source (output valid, status, start_page, page_count, free_fragments,
                  input ready);
  modport sink   (input valid, status, start_page, page_count, free_fragments,
                  output ready);
endinterface

// ===== sv/fpa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/fit_page_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_page_allocator
// Best-fit / worst-fit page allocator with a program table held in RAM.
// ----------------------------------------------------------------------------
// Free requests and rejected requests go from the request transaction through
// the table lookup to the finish step; an allocation that passes the lookup
// also runs the page scan, which walks the free map one page per cycle.
// One request is in flight at a time.
// After reset the table RAM is cleared one entry per cycle; requests wait
// during that pass, configuration writes are taken throughout.
module fit_page_allocator import fpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fpa_req_if.sink    req,
  fpa_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_LOOKUP = 5'b00100,
    S_SCAN   = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  logic                 fit_mode;
  logic [NUM_PAGES-1:0] free_map;
  logic [FRAG_W-1:0]    frag;
  logic [ID_AW-1:0]     clr_addr;

  logic                 op_q;
  logic [ID_AW-1:0]     id_q;
  logic [SIZE_W-1:0]    size_q;
  logic [NEED_W-1:0]    need_q;

  logic [COUNT_W-1:0]   scan_p;
  logic                 in_run;
  logic [PAGE_W-1:0]    run_start;
  logic [COUNT_W-1:0]   run_len;
  logic                 found;
  logic [PAGE_W-1:0]    best_start;
  logic [COUNT_W-1:0]   best_len;

  logic [STATUS_W-1:0]  res_status;
  logic [PAGE_W-1:0]    res_start;
  logic [COUNT_W-1:0]   res_count;
  logic                 res_full;

  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [PAGE_W-1:0]    out_start;
  logic [COUNT_W-1:0]   out_count;
  logic [FRAG_W-1:0]    out_frag;

  logic                 tbl_we;
  logic [ID_AW-1:0]     tbl_waddr;
  tbl_entry_t           tbl_wdata;
  tbl_entry_t           tbl_rdata;

  logic                 req_fire;
  logic                 finish_fire;
  logic                 page_is_free;
  logic                 take_run;
  logic                 found_next;
  logic [PAGE_W-1:0]    best_start_next;
  logic [COUNT_W-1:0]   best_len_next;
  logic [NEED_W-1:0]    need_calc;
  logic [NUM_PAGES-1:0] res_mask;
  logic                 left_free;
  logic                 right_free;
  logic [COUNT_W:0]     right_idx;
  logic [FRAG_W:0]      frag_after_free;
  logic [FRAG_W-1:0]    frag_next;
  logic [NUM_PAGES-1:0] free_map_next;

  assign req.ready   = (state == S_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign finish_fire = (state == S_FINISH) && (!out_valid || rsp.ready);

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.start_page     = out_start;
  assign rsp.page_count     = out_count;
  assign rsp.free_fragments = out_frag;

  fpa_ram #(
    .WIDTH (TBL_W),
    .DEPTH (NUM_IDS)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (req.program_id[ID_AW-1:0]),
    .rdata (tbl_rdata)
  );

  // Pages needed: size rounded up to 4 KB.
  always_comb begin
    logic [SIZE_W:0] sum;
    sum       = (SIZE_W+1)'(size_q) + (SIZE_W+1)'(3);
    need_calc = sum[SIZE_W:2];
  end

  // One page of the scan: extend the current run or close it and judge it.
  always_comb begin
    page_is_free    = (scan_p != COUNT_W'(NUM_PAGES)) && free_map[scan_p[PAGE_W-1:0]];
    take_run        = 1'b0;
    found_next      = found;
    best_start_next = best_start;
    best_len_next   = best_len;
    if (in_run && !page_is_free && (NEED_W'(run_len) >= need_q)) begin
      if (!found) begin
        take_run = 1'b1;
      end else if (fit_mode == MODE_BEST) begin
        take_run = run_len < best_len;
      end else begin
        take_run = run_len > best_len;
      end
    end
    if (take_run) begin
      found_next      = 1'b1;
      best_start_next = run_start;
      best_len_next   = run_len;
    end
  end

  // Free-map and fragment-count update for a successful request. Freed pages
  // were all allocated, so the run count changes only by their neighbors.
  always_comb begin
    res_mask        = range_mask(res_start, res_count);
    right_idx       = (COUNT_W+1)'(res_start) + (COUNT_W+1)'(res_count);
    left_free       = (res_start != '0) && free_map[res_start - PAGE_W'(1)];
    right_free      = (right_idx < (COUNT_W+1)'(NUM_PAGES)) &&
                      free_map[right_idx[PAGE_W-1:0]];
    frag_after_free = (FRAG_W+1)'(frag) + (FRAG_W+1)'(1)
                      - (FRAG_W+1)'(left_free) - (FRAG_W+1)'(right_free);
    free_map_next   = free_map;
    frag_next       = frag;
    if (res_status == ST_OK) begin
      if (op_q == REQ_ALLOC) begin
        free_map_next = free_map & ~res_mask;
        frag_next     = frag - FRAG_W'(res_full);
      end else begin
        free_map_next = free_map | res_mask;
        frag_next     = frag_after_free[FRAG_W-1:0];
      end
    end
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = id_q;
    tbl_wdata = '0;
    if (state == S_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_addr;
    end else if (finish_fire && (res_status == ST_OK)) begin
      tbl_we = 1'b1;
      if (op_q == REQ_ALLOC) begin
        tbl_wdata.valid = 1'b1;
        tbl_wdata.start = res_start;
        tbl_wdata.count = res_count;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == ID_AW'(NUM_IDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if ((op_q == REQ_ALLOC) && (size_q != '0) && !tbl_rdata.valid) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        if (scan_p == COUNT_W'(NUM_PAGES)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (finish_fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      fit_mode  <= MODE_BEST;
      free_map  <= '1;
      frag      <= FRAG_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ID_AW'(1);
      end
      if (cfg_we) begin
        fit_mode <= cfg_wdata;
      end
      if (finish_fire) begin
        free_map  <= free_map_next;
        frag      <= frag_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_q   <= req.req_type;
      id_q   <= req.program_id[ID_AW-1:0];
      size_q <= req.size_kb;
    end
    case (state)
      S_LOOKUP: begin
        need_q     <= need_calc;
        scan_p     <= '0;
        in_run     <= 1'b0;
        found      <= 1'b0;
        best_start <= '0;
        best_len   <= '0;
        res_full   <= 1'b0;
        res_status <= ST_OK;
        res_start  <= '0;
        res_count  <= '0;
        if (op_q == REQ_ALLOC) begin
          if (size_q == '0) begin
            res_status <= ST_BAD_SIZE;
          end else if (tbl_rdata.valid) begin
            res_status <= ST_DUP;
          end
        end else if (!tbl_rdata.valid) begin
          res_status <= ST_NOT_FOUND;
        end else begin
          res_start <= tbl_rdata.start;
          res_count <= tbl_rdata.count;
        end
      end
      S_SCAN: begin
        scan_p     <= scan_p + COUNT_W'(1);
        found      <= found_next;
        best_start <= best_start_next;
        best_len   <= best_len_next;
        if (page_is_free) begin
          if (!in_run) begin
            run_start <= scan_p[PAGE_W-1:0];
            run_len   <= COUNT_W'(1);
          end else begin
            run_len <= run_len + COUNT_W'(1);
          end
        end
        in_run <= page_is_free;
        if (scan_p == COUNT_W'(NUM_PAGES)) begin
          if (found_next) begin
            res_status <= ST_OK;
            res_start  <= best_start_next;
            res_count  <= need_q[COUNT_W-1:0];
            res_full   <= (NEED_W'(best_len_next) == need_q);
          end else begin
            res_status <= ST_NO_SPACE;
          end
        end
      end
      default: begin
      end
    endcase
    if (finish_fire) begin
      out_status <= res_status;
      out_start  <= res_start;
      out_count  <= res_count;
      out_frag   <= frag_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_frag_matches_map: assert property (@(posedge clk) disable iff (rst)
    $countones(free_map & ~{free_map[NUM_PAGES-2:0], 1'b0}) == 32'(frag))
    else $error("fragment count disagrees with the free map");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("response raised outside the finish step");

  a_ok_has_pages: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status == ST_OK)) |-> (out_count != '0))
    else $error("successful transaction with no pages");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan_p <= COUNT_W'(NUM_PAGES)))
    else $error("page scan ran past the last page");
`endif

endmodule
